// ----- rtl/lkdw_pkg.sv -----
// Shared constants for the longest k-distinct window block.
`default_nettype none

package lkdw_pkg;

    // Fixed widths of the channel fields and the configuration register
    localparam int VALUE_W = 10;
    localparam int CFG_W   = 11;
    localparam int OUT_W   = 11;

    // Sequence tag held beside each count entry; a stale tag reads as zero
    localparam int EPOCH_W = 4;

    // Reset value of the distinct-value limit
    localparam logic [CFG_W-1:0] MAX_DISTINCT_RST = 11'd1;

endpackage

`default_nettype wire

// ----- rtl/longest_k_distinct_window.sv -----
// Longest window holding at most max_distinct distinct values: top level.
//
// Input channel (i_valid / o_ready) carries one value per beat, i_last marks
// the final beat of a sequence. Output channel (o_valid / i_ready) gives one
// beat per sequence: 1-based start and end of the longest window, earliest
// on ties. Configuration: i_cfg_wr_en writes i_cfg_wr_data to max_distinct.
//
// Sequencing: an accepted beat is added to the count table, then elements
// are evicted from the left while the window holds more than max_distinct
// distinct values, then the best window is checked; the next beat is not
// taken before this is done. A beat past MAX_LEN is dropped. Every element
// is evicted at most once. A single sequencer walks the count table: read,
// then modify and write back, one access per cycle. The result sits in an output
// register, so the next sequence is taken while it waits; only a second
// last beat stalls if the first result has not yet been taken.
//
// Reset (synchronous, active low) starts a clearing pass that writes all
// 2^VALUE_BITS count table entries, during which o_ready is low. Count entries
// carry a sequence tag, so the end of a sequence needs no sweep; the pass
// repeats only once every 2^EPOCH_W sequences, when the tag wraps.
`default_nettype none

module longest_k_distinct_window #(
    parameter int MAX_LEN    = 1024,
    parameter int VALUE_BITS = 10
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration
    input  wire                          i_cfg_wr_en,
    input  wire [lkdw_pkg::CFG_W-1:0]    i_cfg_wr_data,
    // input beats
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [lkdw_pkg::VALUE_W-1:0]  i_value,
    input  wire                          i_last,
    // result beats
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [lkdw_pkg::OUT_W-1:0]   o_best_start,
    output logic [lkdw_pkg::OUT_W-1:0]   o_best_end
);

    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int EP_W    = lkdw_pkg::EPOCH_W;
    localparam int ENT_W   = EP_W + CNT_W;
    localparam int CMP_W   = (CNT_W > lkdw_pkg::CFG_W) ? CNT_W : lkdw_pkg::CFG_W;
    localparam int SUM_W   = ((IDX_W > lkdw_pkg::OUT_W) ? IDX_W : lkdw_pkg::OUT_W) + 1;
    localparam int VEXT_W  = (VALUE_BITS > lkdw_pkg::VALUE_W) ? VALUE_BITS
                                                              : lkdw_pkg::VALUE_W;
    localparam int N_VALS  = 1 << VALUE_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_EVCHK,
        S_EVRD,
        S_EVCT,
        S_BEST,
        S_OUT
    } t_state;

    // Registers
    t_state                    r_state,   n_state;
    logic [lkdw_pkg::CFG_W-1:0] r_max,    n_max;
    logic [EP_W-1:0]           r_epoch,   n_epoch;
    logic [VALUE_BITS-1:0]     r_clr,     n_clr;
    logic [CNT_W-1:0]          r_dist,    n_dist;
    logic [CNT_W-1:0]          r_left,    n_left;
    logic [CNT_W-1:0]          r_right,   n_right;
    logic [CNT_W-1:0]          r_blen,    n_blen;
    logic [IDX_W-1:0]          r_bleft,   n_bleft;
    logic [IDX_W-1:0]          r_bright,  n_bright;
    logic                      r_last,    n_last;
    logic [VALUE_BITS-1:0]     r_val,     n_val;
    logic [VALUE_BITS-1:0]     r_old,     n_old;
    logic                      r_ovalid,  n_ovalid;
    logic [lkdw_pkg::OUT_W-1:0] r_ostart, n_ostart;
    logic [lkdw_pkg::OUT_W-1:0] r_oend,   n_oend;

    // Memory ports
    logic                  vs_we, vs_re;
    logic [IDX_W-1:0]      vs_waddr, vs_raddr;
    logic [VALUE_BITS-1:0] vs_rdata;
    logic                  ct_we, ct_re;
    logic [VALUE_BITS-1:0] ct_waddr, ct_raddr;
    logic [ENT_W-1:0]      ct_wdata, ct_rdata;

    // Datapath helpers
    logic [VEXT_W-1:0]     v_ext;
    logic [VALUE_BITS-1:0] v_in;
    logic [CNT_W-1:0]      cnt_cur;
    logic [CNT_W-1:0]      win_len;
    logic [SUM_W-1:0]      start_sum, end_sum;

    assign v_ext = VEXT_W'(i_value);
    assign v_in  = v_ext[VALUE_BITS-1:0];

    // stale tag means the entry belongs to an earlier sequence: count zero
    assign cnt_cur = (ct_rdata[ENT_W-1 -: EP_W] == r_epoch) ? ct_rdata[CNT_W-1:0]
                                                           : '0;
    assign win_len   = r_right - r_left;
    assign start_sum = SUM_W'(r_bleft) + SUM_W'(1);
    assign end_sum   = SUM_W'(r_bright) + SUM_W'(1);

    lkdw_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_LEN)
    ) u_value_store (
        .i_clk     (i_clk),
        .i_wr_en   (vs_we),
        .i_wr_addr (vs_waddr),
        .i_wr_data (r_val),
        .i_rd_en   (vs_re),
        .i_rd_addr (vs_raddr),
        .o_rd_data (vs_rdata)
    );

    lkdw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (N_VALS)
    ) u_count_table (
        .i_clk     (i_clk),
        .i_wr_en   (ct_we),
        .i_wr_addr (ct_waddr),
        .i_wr_data (ct_wdata),
        .i_rd_en   (ct_re),
        .i_rd_addr (ct_raddr),
        .o_rd_data (ct_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_max    = i_cfg_wr_en ? i_cfg_wr_data : r_max;
        n_epoch  = r_epoch;
        n_clr    = r_clr;
        n_dist   = r_dist;
        n_left   = r_left;
        n_right  = r_right;
        n_blen   = r_blen;
        n_bleft  = r_bleft;
        n_bright = r_bright;
        n_last   = r_last;
        n_val    = r_val;
        n_old    = r_old;
        n_ovalid = r_ovalid & ~i_ready;
        n_ostart = r_ostart;
        n_oend   = r_oend;

        vs_we    = 1'b0;
        vs_waddr = r_right[IDX_W-1:0];
        vs_re    = 1'b0;
        vs_raddr = r_left[IDX_W-1:0];
        ct_we    = 1'b0;
        ct_waddr = r_val;
        ct_wdata = {r_epoch, CNT_W'(cnt_cur + CNT_W'(1))};
        ct_re    = 1'b0;
        ct_raddr = v_in;

        unique case (r_state)
            S_CLEAR: begin
                ct_we    = 1'b1;
                ct_waddr = r_clr;
                ct_wdata = {r_epoch, {CNT_W{1'b0}}};
                n_clr    = r_clr + VALUE_BITS'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_val  = v_in;
                    n_last = i_last;
                    if (r_right < CNT_W'(MAX_LEN)) begin
                        ct_re   = 1'b1;
                        n_state = S_ADD;
                    end else if (i_last) begin
                        // beyond capacity: element dropped, result still due
                        n_state = S_OUT;
                    end
                end
            end
            S_ADD: begin
                vs_we   = 1'b1;
                ct_we   = 1'b1;
                n_right = r_right + CNT_W'(1);
                if (cnt_cur == '0) begin
                    n_dist = r_dist + CNT_W'(1);
                end
                n_state = S_EVCHK;
            end
            S_EVCHK: begin
                if ((CMP_W'(r_dist) > CMP_W'(r_max)) && (r_left < r_right)) begin
                    vs_re   = 1'b1;
                    n_state = S_EVRD;
                end else begin
                    n_state = S_BEST;
                end
            end
            S_EVRD: begin
                ct_re    = 1'b1;
                ct_raddr = vs_rdata;
                n_old    = vs_rdata;
                n_state  = S_EVCT;
            end
            S_EVCT: begin
                ct_waddr = r_old;
                ct_wdata = {r_epoch, CNT_W'(cnt_cur - CNT_W'(1))};
                if (cnt_cur != '0) begin
                    ct_we = 1'b1;
                    if (cnt_cur == CNT_W'(1)) begin
                        n_dist = r_dist - CNT_W'(1);
                    end
                end
                n_left  = r_left + CNT_W'(1);
                n_state = S_EVCHK;
            end
            S_BEST: begin
                if (win_len > r_blen) begin
                    n_blen   = win_len;
                    n_bleft  = r_left[IDX_W-1:0];
                    n_bright = IDX_W'(r_right - CNT_W'(1));
                end
                n_state = r_last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ostart = start_sum[lkdw_pkg::OUT_W-1:0];
                    n_oend   = end_sum[lkdw_pkg::OUT_W-1:0];
                    n_dist   = '0;
                    n_left   = '0;
                    n_right  = '0;
                    n_blen   = '0;
                    n_bleft  = '0;
                    n_bright = '0;
                    n_epoch  = r_epoch + EP_W'(1);
                    // tag wrap: old entries could alias, so sweep the table
                    n_state  = (n_epoch == '0) ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_max    <= lkdw_pkg::MAX_DISTINCT_RST;
            r_epoch  <= '0;
            r_clr    <= '0;
            r_dist   <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_blen   <= '0;
            r_bleft  <= '0;
            r_bright <= '0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_max    <= n_max;
            r_epoch  <= n_epoch;
            r_clr    <= n_clr;
            r_dist   <= n_dist;
            r_left   <= n_left;
            r_right  <= n_right;
            r_blen   <= n_blen;
            r_bleft  <= n_bleft;
            r_bright <= n_bright;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
        r_val    <= n_val;
        r_old    <= n_old;
        r_ostart <= n_ostart;
        r_oend   <= n_oend;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_best_start = r_ostart;
    assign o_best_end   = r_oend;

    // Window never extends past the stored elements
    a_left_le_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= r_right)
        else $error("left index passed right index");

    // Distinct count bounded by window length
    a_dist_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist <= (r_right - r_left))
        else $error("distinct total exceeds window length");

    // Eviction finished before the best window is judged
    a_evict_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BEST) |->
            ((CMP_W'(r_dist) <= CMP_W'(r_max)) || (r_left == r_right)))
        else $error("window still over the distinct limit");

    // A result beat only appears out of the result state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside result state");

    // Best length never beyond stored element count
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blen <= r_right)
        else $error("best length exceeds stored elements");

endmodule

`default_nettype wire

// ----- rtl/lkdw_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module lkdw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire                     i_rd_en,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
